FILE: rtl/lss_pkg.sv
// Shared types and codes for the leftmost substring search block.
package lss_pkg;

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_TEXT    = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned OUT_BITS    = 16;

   typedef enum logic [1:0] {
      OP_PATTERN,
      OP_TEXT,
      OP_END
   } lss_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_CMP
   } lss_state_type;

   typedef struct packed {
      lss_op_type  op;
      logic [7:0]  data_byte;
   } lss_item_type;

   typedef struct packed {
      logic         valid;
      lss_item_type item;
   } lss_queue_type;

endpackage

FILE: rtl/lss_req_if.sv
// Request channel: item kind and data byte with valid/ready.
interface lss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

FILE: rtl/lss_rsp_if.sv
// Response channel: search result with valid/ready.
interface lss_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [15:0] match_start;
   logic [15:0] text_length;
   logic        pattern_too_long;

   modport source (output valid, output found, output match_start, output text_length,
                   output pattern_too_long, input ready);
   modport sink (input valid, input found, input match_start, input text_length,
                 input pattern_too_long, output ready);
endinterface

FILE: rtl/leftmost_substring_search.sv
// Top level of the leftmost substring search block.
// Leftmost substring search (KMP). Pattern beats (kind 0) are stored and the
// fallback table is built as they arrive; text beats (kind 1) then run through
// the matcher, and an end beat (kind 2) returns one result and clears the block
// for the next search. The front end takes one beat per cycle while its
// two-entry queue has room, and drops kind 3. The back end handles a beat that
// needs no compare (a dropped pattern or text beat, a beat after a match) in
// the idle state alone; a compared pattern or text beat goes on to the compare
// state, where every fallback step is one registered read of the pattern store
// and fallback table. An end beat is taken once the result register is free.
module leftmost_substring_search
   import lss_pkg::*;
#(
   parameter int unsigned MAX_PATTERN   = 64,
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   lss_req_if.sink   req_ch,
   lss_rsp_if.source rsp_ch
);

   lss_queue_type q_head;
   logic          q_pop;

   lss_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   lss_back #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: rtl/lss_front.sv
// Front end: takes request beats, classifies the kind and queues them.
module lss_front
   import lss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   lss_req_if.sink       req_ch,
   output lss_queue_type q_head,
   input  logic          q_pop
);

   lss_item_type q_mem_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   fill_ff;
   logic [1:0]   fill_in;
   logic         push;
   lss_item_type item_in;
   logic         pop;

   assign req_ch.ready = (fill_ff != 2'(QUEUE_DEPTH));

   always_comb begin
      item_in.data_byte = req_ch.data_byte;
      item_in.op        = OP_PATTERN;
      push              = 1'b0;
      unique case (req_ch.kind)
         KIND_PATTERN: begin
            item_in.op = OP_PATTERN;
            push       = req_ch.valid && req_ch.ready;
         end
         KIND_TEXT: begin
            item_in.op = OP_TEXT;
            push       = req_ch.valid && req_ch.ready;
         end
         KIND_END: begin
            item_in.op = OP_END;
            push       = req_ch.valid && req_ch.ready;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign pop          = q_pop && (fill_ff != 2'd0);
   assign q_head.valid = (fill_ff != 2'd0);
   assign q_head.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + 2'd1))
      else $error("queue fill did not track a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0 || fill_ff == 2'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");
`endif

endmodule

FILE: rtl/lss_back.sv
// Back end: pattern store, fallback table build and KMP matcher with result register.
module lss_back
   import lss_pkg::*;
#(
   parameter int unsigned MAX_PATTERN   = 64,
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  lss_queue_type q_head,
   output logic          q_pop,
   lss_rsp_if.source     rsp_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int unsigned SW    = (POSITION_BITS > CNT_W) ? POSITION_BITS : CNT_W;
   localparam int unsigned PW    = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;

   logic [7:0]       pstore_mem [MAX_PATTERN];
   logic [IDX_W-1:0] ftab_mem   [MAX_PATTERN];
   logic [7:0]       p_rdata_ff;
   logic [IDX_W-1:0] f_rdata_ff;
   logic [IDX_W-1:0] p_addr;
   logic [IDX_W-1:0] f_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_pdata;
   logic [IDX_W-1:0] wr_fdata;

   lss_state_type state_ff, state_in;
   logic                     is_text_ff, is_text_in;
   logic [7:0]               byte_ff, byte_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [CNT_W-1:0]         lim_ff, lim_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         build_ff, build_in;
   logic [IDX_W-1:0]         matched_ff, matched_in;
   logic [POSITION_BITS-1:0] text_ff, text_in;
   logic                     hit_ff, hit_in;
   logic [POSITION_BITS-1:0] hitpos_ff, hitpos_in;
   logic                     ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [OUT_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [OUT_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic                rsp_long_ff, rsp_long_in;

   logic             eq;
   logic [CNT_W-1:0] j_ext;
   logic [CNT_W-1:0] j_final;
   logic [SW-1:0]    pos_diff;
   logic [PW-1:0]    start_ext;
   logic [PW-1:0]    len_ext;
   logic             ans_found;

   assign eq        = (p_rdata_ff == byte_ff);
   assign j_ext     = CNT_W'(j_ff);
   assign j_final   = eq ? (j_ext + CNT_W'(1)) : j_ext;
   assign pos_diff  = SW'(text_ff) - SW'(lim_ff);
   assign ans_found = !ovf_ff && ((count_ff == '0) || hit_ff);
   assign start_ext = PW'((!ovf_ff && (count_ff != '0) && hit_ff) ? hitpos_ff : '0);
   assign len_ext   = PW'(text_ff);

   always_comb begin
      state_in     = state_ff;
      is_text_in   = is_text_ff;
      byte_in      = byte_ff;
      j_in         = j_ff;
      lim_in       = lim_ff;
      count_in     = count_ff;
      build_in     = build_ff;
      matched_in   = matched_ff;
      text_in      = text_ff;
      hit_in       = hit_ff;
      hitpos_in    = hitpos_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_long_in  = rsp_long_ff;
      q_pop        = 1'b0;
      p_addr       = j_ff;
      f_addr       = j_ff - IDX_W'(1);
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_pdata     = byte_ff;
      wr_fdata     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               unique case (q_head.item.op)
                  OP_PATTERN: begin
                     q_pop = 1'b1;
                     if (text_ff != '0) begin
                        q_pop = 1'b1;
                     end else if (count_ff == CNT_W'(MAX_PATTERN)) begin
                        ovf_in = 1'b1;
                     end else if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_pdata = q_head.item.data_byte;
                        wr_fdata = '0;
                        build_in = '0;
                        count_in = CNT_W'(1);
                     end else begin
                        is_text_in = 1'b0;
                        byte_in    = q_head.item.data_byte;
                        j_in       = build_ff;
                        lim_in     = count_ff;
                        p_addr     = build_ff;
                        f_addr     = build_ff - IDX_W'(1);
                        state_in   = ST_CMP;
                     end
                  end
                  OP_TEXT: begin
                     q_pop = 1'b1;
                     if (!(&text_ff)) begin
                        text_in = text_ff + POSITION_BITS'(1);
                        if (!(hit_ff || ovf_ff || (count_ff == '0))) begin
                           is_text_in = 1'b1;
                           byte_in    = q_head.item.data_byte;
                           j_in       = matched_ff;
                           lim_in     = count_ff;
                           p_addr     = matched_ff;
                           f_addr     = matched_ff - IDX_W'(1);
                           state_in   = ST_CMP;
                        end
                     end
                  end
                  OP_END: begin
                     if (!rsp_valid_ff) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_found_in = ans_found;
                        rsp_start_in = start_ext[OUT_BITS-1:0];
                        rsp_len_in   = len_ext[OUT_BITS-1:0];
                        rsp_long_in  = ovf_ff;
                        count_in     = '0;
                        build_in     = '0;
                        matched_in   = '0;
                        text_in      = '0;
                        hit_in       = 1'b0;
                        hitpos_in    = '0;
                        ovf_in       = 1'b0;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_CMP: begin
            if ((j_ff != '0) && !eq && (j_ext < lim_ff)) begin
               j_in   = f_rdata_ff;
               p_addr = f_rdata_ff;
               f_addr = f_rdata_ff - IDX_W'(1);
            end else begin
               state_in = ST_IDLE;
               if (!is_text_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = lim_ff[IDX_W-1:0];
                  wr_pdata = byte_ff;
                  wr_fdata = j_final[IDX_W-1:0];
                  build_in = j_final[IDX_W-1:0];
                  count_in = lim_ff + CNT_W'(1);
               end else if (j_final >= lim_ff) begin
                  hit_in     = 1'b1;
                  hitpos_in  = pos_diff[POSITION_BITS-1:0];
                  matched_in = '0;
               end else begin
                  matched_in = j_final[IDX_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pstore_mem[wr_addr] <= wr_pdata;
         ftab_mem[wr_addr]   <= wr_fdata;
      end
      p_rdata_ff <= pstore_mem[p_addr];
      f_rdata_ff <= ftab_mem[f_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         build_ff     <= '0;
         matched_ff   <= '0;
         text_ff      <= '0;
         hit_ff       <= 1'b0;
         hitpos_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         build_ff     <= build_in;
         matched_ff   <= matched_in;
         text_ff      <= text_in;
         hit_ff       <= hit_in;
         hitpos_ff    <= hitpos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_text_ff   <= is_text_in;
      byte_ff      <= byte_in;
      j_ff         <= j_in;
      lim_ff       <= lim_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_long_ff  <= rsp_long_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.found            = rsp_found_ff;
   assign rsp_ch.match_start      = rsp_start_ff;
   assign rsp_ch.text_length      = rsp_len_ff;
   assign rsp_ch.pattern_too_long = rsp_long_ff;

`ifndef SYNTHESIS
   a_matched_bound: assert property (@(posedge clock) disable iff (reset)
      (matched_ff == '0) || (CNT_W'(matched_ff) < count_ff))
      else $error("matched prefix not below pattern length");
   a_build_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (CNT_W'(build_ff) < count_ff))
      else $error("build prefix not below pattern length");
   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (j_ext < lim_ff))
      else $error("fallback index beyond limit");
   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_long_ff))
      else $error("found reported with an oversized pattern");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && $past(rsp_valid_ff) == 1'b0 && rsp_valid_in && !$past(reset))
      |=> (count_ff == '0 && text_ff == '0 && !hit_ff && !ovf_ff))
      else $error("search state not cleared after a result");
`endif

endmodule

FILE: test/lss_checker.sv
// Watches both channels, predicts each search result and compares it with what the block returns.
module lss_checker
   import lss_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = 64
) (
   input  logic  clock,
   input  logic  reset,
   lss_req_if    req_mon,
   lss_rsp_if    rsp_mon,
   output int    mismatch_count,
   output int    results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;
   localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   typedef struct packed {
      logic        found;
      logic [15:0] match_start;
      logic [15:0] text_length;
      logic        too_long;
   } search_result_type;

   search_result_type expected_results[$];

   logic [7:0]  pat_mem[MAX_PATTERN];
   logic [6:0]  fall_tab[MAX_PATTERN];
   logic [6:0]  pat_len;
   logic [6:0]  build_len;
   logic [6:0]  match_len;
   logic [15:0] text_len;
   logic        hit;
   logic [15:0] hit_at;
   logic        overflow;

   function automatic void clear_search();
      pat_len   = '0;
      build_len = '0;
      match_len = '0;
      text_len  = '0;
      hit       = 1'b0;
      hit_at    = '0;
      overflow  = 1'b0;
   endfunction

   function automatic void add_pattern_byte(logic [7:0] b);
      logic [6:0] j;
      j = build_len;
      if (pat_len >= MAX_PATTERN) begin
         overflow = 1'b1;
         return;
      end
      pat_mem[IDX_W'(pat_len)] = b;
      if (pat_len == 0) begin
         fall_tab[0] = '0;
         build_len   = '0;
      end else begin
         while (j > 0 && j < pat_len && pat_mem[IDX_W'(j)] != b)
            j = fall_tab[IDX_W'(j - 7'd1)];
         if (j < pat_len && pat_mem[IDX_W'(j)] == b)
            j++;
         fall_tab[IDX_W'(pat_len)] = j;
         build_len                 = j;
      end
      pat_len++;
   endfunction

   function automatic void scan_text_byte(logic [7:0] b);
      logic [6:0]  j;
      logic [15:0] pos;
      j   = match_len;
      pos = text_len;
      if (text_len == COUNT_LIMIT)
         return;
      text_len++;
      if (hit || overflow || pat_len == 0)
         return;
      while (j > 0 && j < pat_len && pat_mem[IDX_W'(j)] != b)
         j = fall_tab[IDX_W'(j - 7'd1)];
      if (j < pat_len && pat_mem[IDX_W'(j)] == b)
         j++;
      if (j >= pat_len) begin
         hit    = 1'b1;
         hit_at = pos + 16'd1 - 16'(pat_len);
         j      = '0;
      end
      match_len = j;
   endfunction

   function automatic search_result_type close_search();
      search_result_type r;
      r.found       = overflow ? 1'b0 : (pat_len == 0) ? 1'b1 : hit;
      r.match_start = (!overflow && pat_len != 0 && hit) ? hit_at : 16'd0;
      r.text_length = text_len;
      r.too_long    = overflow;
      clear_search();
      return r;
   endfunction

   function automatic int field_differs(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial clear_search();

   always @(posedge clock) begin : monitor
      search_result_type got;
      search_result_type want;
      int                errs;
      errs = 0;
      if (reset) begin
         clear_search();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.found       = rsp_mon.found;
            got.match_start = rsp_mon.match_start;
            got.text_length = rsp_mon.text_length;
            got.too_long    = rsp_mon.pattern_too_long;
            if (expected_results.size() == 0) begin
               $error("result beat with no search pending");
               errs++;
            end else begin
               want = expected_results.pop_front();
               errs += field_differs("found", 16'(want.found), 16'(got.found));
               errs += field_differs("match_start", want.match_start, got.match_start);
               errs += field_differs("text_length", want.text_length, got.text_length);
               errs += field_differs("pattern_too_long", 16'(want.too_long),
                                     16'(got.too_long));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            unique case (req_mon.kind)
               KIND_PATTERN: begin
                  if (text_len == 0)
                     add_pattern_byte(req_mon.data_byte);
               end
               KIND_TEXT: scan_text_byte(req_mon.data_byte);
               KIND_END: expected_results.push_back(close_search());
               default: ;
            endcase
         end
      end
      mismatch_count  <= mismatch_count + errs;
      results_pending <= expected_results.size();
   end

endmodule

FILE: test/testbench.sv
// Top of the search testbench: clock, reset, request and result traffic, and the verdict.
module testbench;
   import lss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_BEATS = 750;

   logic clock;
   logic reset;
   int   failures;
   int   results_pending;
   int   beats_counted;
   int   cycle_count;
   bit   send_burst;
   bit   take_burst;
   logic [7:0] symbols[4];
   int   n_symbols;

   lss_req_if req_bus ();
   lss_rsp_if rsp_bus ();

   leftmost_substring_search uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   lss_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (failures),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.data_byte <= data;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beats_counted++;
   endtask

   task automatic wait_for_results();
      while (results_pending != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol();
      if (n_symbols == 0)
         return 8'($urandom);
      return symbols[$urandom_range(0, n_symbols - 1)];
   endfunction

   task automatic maybe_noise();
      if ($urandom_range(0, 19) == 0)
         send_beat(KIND_UNUSED, 8'($urandom));
   endtask

   // one search, mostly built from a small alphabet so that partial matches and fallbacks are common
   task automatic random_search(input bit force_long);
      logic [7:0] pat[$];
      logic [7:0] txt[$];
      int r, pat_n, txt_n, at, i;
      bit late_pattern;
      send_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      n_symbols = (r < 6) ? 2 : (r < 8) ? 3 : 0;
      foreach (symbols[k])
         symbols[k] = 8'($urandom);
      r = $urandom_range(0, 99);
      if (force_long || r >= 97)
         pat_n = $urandom_range(65, 70);
      else if (r < 70)
         pat_n = $urandom_range(0, 6);
      else if (r < 90)
         pat_n = $urandom_range(7, 20);
      else
         pat_n = $urandom_range(40, 64);
      for (i = 0; i < pat_n; i++)
         pat.push_back(pick_symbol());
      txt_n = $urandom_range(0, 24);
      if ($urandom_range(0, 1) == 1)
         txt_n += pat_n;
      for (i = 0; i < txt_n; i++)
         txt.push_back(pick_symbol());
      if (pat_n > 0 && pat_n <= txt_n && $urandom_range(0, 1) == 1) begin
         at = $urandom_range(0, txt_n - pat_n);
         for (i = 0; i < pat_n; i++)
            txt[at + i] = pat[i];
      end
      late_pattern = ($urandom_range(0, 7) == 0);
      foreach (pat[k]) begin
         maybe_noise();
         send_beat(KIND_PATTERN, pat[k]);
      end
      foreach (txt[k]) begin
         maybe_noise();
         send_beat(KIND_TEXT, txt[k]);
         if (late_pattern && k == 0)
            send_beat(KIND_PATTERN, pick_symbol());
      end
      maybe_noise();
      send_beat(KIND_END, 8'($urandom));
   endtask

   // result side: random stalls per beat, with stretches of none
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      take_burst = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         if (taken % 8 == 0)
            take_burst = ($urandom_range(0, 2) == 0);
         stall = take_burst ? 0 : $urandom_range(0, 6);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid)
            @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_PATTERN;
      req_bus.data_byte = 8'h00;
      send_burst = 1'b0;
      beats_counted = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pattern, empty text
      send_beat(KIND_END, 8'hFF);
      // match past a false start; bytes after the match only counted, stray beats ignored
      send_beat(KIND_PATTERN, 8'h00);
      send_beat(KIND_PATTERN, 8'hFF);
      send_beat(KIND_TEXT, 8'hFF);
      send_beat(KIND_TEXT, 8'h00);
      send_beat(KIND_UNUSED, 8'hFF);
      send_beat(KIND_PATTERN, 8'h00);
      send_beat(KIND_TEXT, 8'hFF);
      send_beat(KIND_TEXT, 8'h00);
      send_beat(KIND_TEXT, 8'hFF);
      send_beat(KIND_END, 8'h00);
      // pattern longer than the text
      send_beat(KIND_PATTERN, 8'h41);
      send_beat(KIND_PATTERN, 8'h41);
      send_beat(KIND_PATTERN, 8'h41);
      send_beat(KIND_TEXT, 8'h41);
      send_beat(KIND_TEXT, 8'h41);
      send_beat(KIND_END, 8'h00);
      // empty pattern against some text
      send_beat(KIND_TEXT, 8'h5A);
      send_beat(KIND_TEXT, 8'hA5);
      send_beat(KIND_END, 8'h00);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_for_results();

      // pattern overflowing the store
      random_search(1'b1);

      while (beats_counted < RANDOM_BEATS) begin
         random_search(1'b0);
         if ($urandom_range(0, 7) == 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            wait_for_results();
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_for_results();
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
